// ===== rtl/spc_pkg.sv =====
// Shared types, constants and the PEC byte update for the SMBus PEC read checker.
package spc_pkg;

  localparam int MAX_BLOCK_DEFAULT = 32;
  localparam int JOB_QUEUE_DEPTH = 2;
  localparam int MEM_ADDR_W = 8;

  localparam logic [7:0] PEC_POLY = 8'h07;

  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_MAX_BLOCK_LEN = 1'b1;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd11;
  localparam logic [5:0] MAX_BLOCK_LEN_RESET = 6'd4;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_LEN = 2'd1,
    STATUS_PEC     = 2'd2,
    STATUS_BUS     = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] length;
  } job_t;

  typedef struct packed {
    logic                  en;
    logic [MEM_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } mem_wr_t;

  typedef struct packed {
    logic run_done;
  } back_fb_t;

  function automatic logic [7:0] pec_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ PEC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/spc_fifo.sv =====
// Short job queue between the checking front end and the result back end.
module spc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spc_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output spc_pkg::job_t pop_data,
  output logic          empty
);

  localparam int DEPTH = spc_pkg::JOB_QUEUE_DEPTH;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  spc_pkg::job_t   entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("Job popped from an empty queue.");

endmodule

// ===== rtl/spc_front.sv =====
// Front end: accepts response words, keeps the PEC and transaction state, queues the outcome.
module spc_front #(
  parameter int MAX_BLOCK = spc_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               start_req,
  input  logic [7:0]         command_code,
  input  logic               block_read,
  input  logic [7:0]         rx_byte,
  input  logic               bus_error,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               q_full,
  output logic               push,
  output spc_pkg::job_t      push_job,
  output spc_pkg::mem_wr_t   mem_wr,
  input  spc_pkg::back_fb_t  back_fb
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_HDR0 = 5'b00010,
    F_HDR1 = 5'b00100,
    F_HDR2 = 5'b01000,
    F_PROC = 5'b10000
  } fstate_t;

  fstate_t           state;
  logic [6:0]        device_address;
  logic [5:0]        max_block_len;
  logic              active;
  logic              active_next;
  logic              mode_block;
  logic [5:0]        byte_counter;
  logic [5:0]        byte_counter_next;
  logic [5:0]        length_seen;
  logic [5:0]        length_seen_next;
  spc_pkg::status_t  error_code;
  spc_pkg::status_t  error_code_next;
  logic [7:0]        crc_acc;
  logic [7:0]        crc_acc_next;
  logic              run_outstanding;
  logic [7:0]        s_cmd;
  logic [7:0]        s_byte;
  logic              s_berr;
  logic [7:0]        addr_byte;
  logic [7:0]        pec_byte;
  logic [7:0]        pec_out;
  logic [5:0]        eff_max;
  logic              accept;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == F_IDLE) && !q_full && !run_outstanding;
  assign addr_byte = {device_address, 1'b0};
  assign eff_max = ({2'b00, max_block_len} < 8'(MAX_BLOCK)) ? max_block_len : 6'(MAX_BLOCK);

  always_comb begin
    unique case (state)
      F_HDR0:  pec_byte = addr_byte;
      F_HDR1:  pec_byte = s_cmd;
      F_HDR2:  pec_byte = addr_byte | 8'h01;
      default: pec_byte = s_byte;
    endcase
  end

  assign pec_out = spc_pkg::pec_update(crc_acc, pec_byte);

  always_comb begin
    active_next = active;
    byte_counter_next = byte_counter;
    length_seen_next = length_seen;
    error_code_next = error_code;
    crc_acc_next = crc_acc;
    push = 1'b0;
    push_job.status = spc_pkg::STATUS_OK;
    push_job.length = '0;
    mem_wr.en = 1'b0;
    mem_wr.addr = '0;
    mem_wr.data = s_byte;
    if (state == F_PROC && active) begin
      if (s_berr) begin
        push = 1'b1;
        push_job.status = spc_pkg::STATUS_BUS;
        active_next = 1'b0;
      end else begin
        byte_counter_next = byte_counter + 6'd1;
        if (!mode_block) begin
          if (byte_counter < 6'd2) begin
            mem_wr.en = 1'b1;
            mem_wr.addr = spc_pkg::MEM_ADDR_W'(byte_counter);
            crc_acc_next = pec_out;
          end else begin
            push = 1'b1;
            active_next = 1'b0;
            if (s_byte != crc_acc) begin
              push_job.status = spc_pkg::STATUS_PEC;
            end else begin
              push_job.length = 6'd2;
            end
          end
        end else begin
          if (byte_counter == 6'd0) begin
            if (s_byte == 8'd0 || s_byte > {2'b00, eff_max}) begin
              error_code_next = spc_pkg::STATUS_BAD_LEN;
              length_seen_next = '0;
            end else begin
              length_seen_next = s_byte[5:0];
            end
            crc_acc_next = pec_out;
          end else if (error_code == spc_pkg::STATUS_OK && byte_counter <= length_seen) begin
            mem_wr.en = 1'b1;
            mem_wr.addr = spc_pkg::MEM_ADDR_W'(byte_counter - 6'd1);
            crc_acc_next = pec_out;
          end else if (error_code == spc_pkg::STATUS_OK &&
                       {1'b0, byte_counter} == {1'b0, length_seen} + 7'd1) begin
            if (s_byte != crc_acc) begin
              error_code_next = spc_pkg::STATUS_PEC;
            end
          end
          if ({1'b0, byte_counter} >= {1'b0, eff_max} + 7'd1) begin
            push = 1'b1;
            active_next = 1'b0;
            push_job.status = error_code_next;
            push_job.length = (error_code_next == spc_pkg::STATUS_OK) ? length_seen_next : '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cmd <= command_code;
      s_byte <= rx_byte;
      s_berr <= bus_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      device_address <= spc_pkg::DEVICE_ADDRESS_RESET;
      max_block_len <= spc_pkg::MAX_BLOCK_LEN_RESET;
      active <= 1'b0;
      mode_block <= 1'b0;
      byte_counter <= '0;
      length_seen <= '0;
      error_code <= spc_pkg::STATUS_OK;
      crc_acc <= '0;
      run_outstanding <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          spc_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data;
          spc_pkg::REG_MAX_BLOCK_LEN:  max_block_len <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (push && push_job.status == spc_pkg::STATUS_OK) begin
        run_outstanding <= 1'b1;
      end else if (back_fb.run_done) begin
        run_outstanding <= 1'b0;
      end
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (start_req) begin
              active <= 1'b1;
              mode_block <= block_read;
              byte_counter <= '0;
              length_seen <= '0;
              error_code <= spc_pkg::STATUS_OK;
              crc_acc <= '0;
              state <= F_HDR0;
            end else begin
              state <= F_PROC;
            end
          end
        end
        F_HDR0: begin
          crc_acc <= pec_out;
          state <= F_HDR1;
        end
        F_HDR1: begin
          crc_acc <= pec_out;
          state <= F_HDR2;
        end
        F_HDR2: begin
          crc_acc <= pec_out;
          state <= F_PROC;
        end
        F_PROC: begin
          active <= active_next;
          byte_counter <= byte_counter_next;
          length_seen <= length_seen_next;
          error_code <= error_code_next;
          crc_acc <= crc_acc_next;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  a_no_write_under_run: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en |-> !run_outstanding)
    else $error("Payload store written while a validated run is still being read out.");

  a_header_sequence: assert property (@(posedge clk) disable iff (rst)
    (accept && start_req) |=> (state == F_HDR0) ##3 (state == F_PROC))
    else $error("Header PEC sequence did not run to the byte processing step.");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("Outcome queued while the job queue is full.");

endmodule

// ===== rtl/spc_back.sv =====
// Back end: holds the payload store and plays each queued outcome out as result words.
module spc_back #(
  parameter int MAX_BLOCK = spc_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               pop,
  input  spc_pkg::job_t      job,
  input  spc_pkg::mem_wr_t   mem_wr,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [7:0]         data_byte,
  output logic [4:0]         byte_index,
  output logic [5:0]         payload_length,
  output logic               last,
  output spc_pkg::back_fb_t  back_fb
);

  localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_FETCH = 3'b010,
    B_SHOW  = 3'b100
  } bstate_t;

  bstate_t           state;
  logic [7:0]        mem [MAX_BLOCK];
  logic [7:0]        rd_data;
  logic [5:0]        k;
  logic [5:0]        job_len;
  logic              show_err;
  spc_pkg::status_t  out_status;

  assign pop = (state == B_IDLE) && job_valid;
  assign out_valid = (state == B_SHOW);
  assign status = out_status;
  assign data_byte = show_err ? 8'd0 : rd_data;
  assign byte_index = k[4:0];
  assign payload_length = show_err ? 6'd0 : job_len;
  assign last = show_err || ({1'b0, k} + 7'd1 == {1'b0, job_len});
  assign back_fb.run_done = out_valid && out_ready && last && !show_err;

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[AW'(mem_wr.addr)] <= mem_wr.data;
    end
    if (state == B_FETCH) begin
      rd_data <= mem[AW'(k)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      k <= '0;
      job_len <= '0;
      show_err <= 1'b0;
      out_status <= spc_pkg::STATUS_OK;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            job_len <= job.length;
            k <= '0;
            out_status <= job.status;
            if (job.status == spc_pkg::STATUS_OK) begin
              show_err <= 1'b0;
              state <= B_FETCH;
            end else begin
              show_err <= 1'b1;
              state <= B_SHOW;
            end
          end
        end
        B_FETCH: begin
          state <= B_SHOW;
        end
        B_SHOW: begin
          if (out_ready) begin
            if (last) begin
              state <= B_IDLE;
            end else begin
              k <= k + 6'd1;
              state <= B_FETCH;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != spc_pkg::STATUS_OK) |-> (last && payload_length == 6'd0))
    else $error("Error result is not a single final word.");

endmodule

// ===== rtl/smbus_pec_read_checker_core.sv =====
// Top level of the SMBus PEC read checker: front end, job queue and back end.
// A word without start_req is taken and processed in the F_PROC state; a word with start_req
// first passes F_HDR0, F_HDR1 and F_HDR2, as the shared PEC byte unit folds in the address,
// command and read address. The last word of a transaction queues its outcome; the back end
// fetches each further data result from the payload store after the previous one is taken.
// Input is held off while a validated run is read out of the payload store.
// Synchronous active-high reset restores the registers to address 11 and length 4; the
// payload store is not cleared.
module smbus_pec_read_checker_core #(
  parameter int MAX_BLOCK = spc_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       start_req,
  input  logic [7:0] command_code,
  input  logic       block_read,
  input  logic [7:0] rx_byte,
  input  logic       bus_error,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] data_byte,
  output logic [4:0] byte_index,
  output logic [5:0] payload_length,
  output logic       last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  spc_pkg::job_t      push_job;
  spc_pkg::job_t      pop_job;
  spc_pkg::mem_wr_t   mem_wr;
  spc_pkg::back_fb_t  back_fb;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;

  spc_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_req(start_req),
    .command_code(command_code),
    .block_read(block_read),
    .rx_byte(rx_byte),
    .bus_error(bus_error),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_full(q_full),
    .push(push),
    .push_job(push_job),
    .mem_wr(mem_wr),
    .back_fb(back_fb)
  );

  spc_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_job),
    .full(q_full),
    .pop(pop),
    .pop_data(pop_job),
    .empty(q_empty)
  );

  spc_back #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(!q_empty),
    .pop(pop),
    .job(pop_job),
    .mem_wr(mem_wr),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .data_byte(data_byte),
    .byte_index(byte_index),
    .payload_length(payload_length),
    .last(last),
    .back_fb(back_fb)
  );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the SMBus PEC read checker: directed, register and random read traffic.
module tb_top;

  localparam int MAX_BLOCK = spc_pkg::MAX_BLOCK_DEFAULT;
  localparam int TOTAL_WORDS = 270;
  localparam int DRAIN_CYCLES = 32;
  localparam int WATCHDOG_CYCLES = 2000;

  typedef struct packed {
    spc_pkg::status_t status;
    logic [7:0]       data;
    logic [4:0]       idx;
    logic [5:0]       len;
    logic             last;
  } result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       start_req = 1'b0;
  logic [7:0] command_code = 8'h00;
  logic       block_read = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       bus_error = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] status;
  logic [7:0] data_byte;
  logic [4:0] byte_index;
  logic [5:0] payload_length;
  logic       last;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [6:0] cfg_data = 7'd0;

  logic [6:0]       cfg_dev = spc_pkg::DEVICE_ADDRESS_RESET;
  logic [5:0]       cfg_max = spc_pkg::MAX_BLOCK_LEN_RESET;
  logic             model_busy = 1'b0;
  logic             model_block = 1'b0;
  logic [5:0]       model_cnt = 6'd0;
  logic [5:0]       model_len = 6'd0;
  spc_pkg::status_t model_err = spc_pkg::STATUS_OK;
  logic [7:0]       model_crc = 8'h00;
  logic [7:0]       model_store [MAX_BLOCK];

  result_t pending_results [$];
  result_t want;

  logic in_idle_en = 1'b1;
  logic out_idle_en = 1'b1;
  int   out_hold = 0;
  int   stall_cycles = 0;
  int   mismatches = 0;
  int   words_in = 0;
  int   results_seen = 0;
  int   error_results = 0;
  int   reads_done = 0;

  smbus_pec_read_checker_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_req(start_req), .command_code(command_code), .block_read(block_read),
    .rx_byte(rx_byte), .bus_error(bus_error),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data_byte(data_byte), .byte_index(byte_index),
    .payload_length(payload_length), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] pec_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ spc_pkg::PEC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [5:0] eff_limit();
    return (cfg_max < 6'(MAX_BLOCK)) ? cfg_max : 6'(MAX_BLOCK);
  endfunction

  task automatic push_error(input spc_pkg::status_t code);
    pending_results.push_back(result_t'{code, 8'h00, 5'd0, 6'd0, 1'b1});
    model_busy = 1'b0;
  endtask

  task automatic push_run(input int n);
    for (int k = 0; k < n; k++) begin
      pending_results.push_back(result_t'{spc_pkg::STATUS_OK, model_store[k], 5'(k), 6'(n),
                                           k == n - 1});
    end
    model_busy = 1'b0;
  endtask

  task automatic predict_read_outcome(input logic s, input logic [7:0] cmd, input logic blk,
                                      input logic [7:0] b, input logic be);
    logic [7:0] addr_w;
    logic [5:0] pos;
    logic [5:0] mx;
    addr_w = {cfg_dev, 1'b0};
    if (s) begin
      model_busy = 1'b1;
      model_block = blk;
      model_cnt = 6'd0;
      model_len = 6'd0;
      model_err = spc_pkg::STATUS_OK;
      model_crc = pec_fold(pec_fold(pec_fold(8'h00, addr_w), cmd), addr_w | 8'h01);
    end
    if (!model_busy) return;
    if (be) begin
      push_error(spc_pkg::STATUS_BUS);
      return;
    end
    pos = model_cnt;
    model_cnt = model_cnt + 6'd1;
    if (!model_block) begin
      if (pos < 2) begin
        model_store[pos] = b;
        model_crc = pec_fold(model_crc, b);
      end else if (b != model_crc) begin
        push_error(spc_pkg::STATUS_PEC);
      end else begin
        push_run(2);
      end
      return;
    end
    mx = eff_limit();
    if (pos == 0) begin
      if (b == 0 || b > mx) begin
        model_err = spc_pkg::STATUS_BAD_LEN;
        model_len = 6'd0;
      end else begin
        model_len = b[5:0];
      end
      model_crc = pec_fold(model_crc, b);
    end else if (model_err == spc_pkg::STATUS_OK && pos <= model_len) begin
      model_store[pos - 6'd1] = b;
      model_crc = pec_fold(model_crc, b);
    end else if (model_err == spc_pkg::STATUS_OK && pos == model_len + 6'd1) begin
      if (b != model_crc) model_err = spc_pkg::STATUS_PEC;
    end
    if (pos >= mx + 6'd1) begin
      if (model_err != spc_pkg::STATUS_OK) push_error(model_err);
      else push_run(model_len);
    end
  endtask

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic send_word(input logic s, input logic [7:0] cmd, input logic blk,
                           input logic [7:0] b, input logic be);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    start_req <= s;
    command_code <= cmd;
    block_read <= blk;
    rx_byte <= b;
    bus_error <= be;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (s || model_busy) words_in++;
    predict_read_outcome(s, cmd, blk, b, be);
  endtask

  task automatic settle();
    if (model_busy) send_word(1'b0, 8'($urandom), 1'($urandom), 8'($urandom), 1'b1);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == spc_pkg::REG_DEVICE_ADDRESS) cfg_dev = val;
    else cfg_max = val[5:0];
  endtask

  task automatic do_read(input logic blk, input logic [7:0] cmd, input logic [7:0] len_byte,
                         input logic [7:0] pec_flip, input int cut, input int berr_at,
                         input int fill);
    logic [7:0] addr_w;
    logic [7:0] crc;
    logic [7:0] d;
    logic [7:0] seq [$];
    int mx;
    int dlen;
    int n;
    addr_w = {cfg_dev, 1'b0};
    crc = pec_fold(pec_fold(pec_fold(8'h00, addr_w), cmd), addr_w | 8'h01);
    mx = eff_limit();
    dlen = blk ? ((len_byte == 0 || len_byte > mx) ? 0 : int'(len_byte)) : 2;
    if (blk) begin
      seq.push_back(len_byte);
      crc = pec_fold(crc, len_byte);
    end
    for (int k = 0; k < dlen; k++) begin
      d = (fill < 0) ? 8'($urandom) : ((k % 2) ? ~8'(fill) : 8'(fill));
      seq.push_back(d);
      crc = pec_fold(crc, d);
    end
    seq.push_back(crc ^ pec_flip);
    while (blk && seq.size() < mx + 2) seq.push_back(8'($urandom));
    n = (cut >= 0 && cut < seq.size()) ? cut : seq.size();
    reads_done++;
    for (int i = 0; i < n; i++) begin
      if (i == berr_at) begin
        send_word(i == 0, (i == 0) ? cmd : 8'($urandom), (i == 0) ? blk : 1'($urandom),
                  8'($urandom), 1'b1);
        return;
      end
      send_word(i == 0, (i == 0) ? cmd : 8'($urandom), (i == 0) ? blk : 1'($urandom),
                seq[i], 1'b0);
    end
  endtask

  task automatic rand_read();
    int pick;
    int mx;
    int nb;
    logic blk;
    logic [7:0] cmd;
    logic [7:0] len;
    pick = $urandom_range(0, 99);
    blk = 1'($urandom);
    cmd = 8'($urandom);
    mx = eff_limit();
    nb = blk ? mx + 2 : 3;
    len = (mx == 0) ? 8'd0 : 8'($urandom_range(1, mx));
    if (pick < 70) begin
      do_read(blk, cmd, len, 8'h00, -1, -1, -1);
    end else if (pick < 78) begin
      do_read(blk, cmd, len, 8'($urandom_range(1, 255)), -1, -1, -1);
    end else if (pick < 85) begin
      do_read(1'b1, cmd, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(mx + 1, 255)),
              8'($urandom), -1, -1, -1);
    end else if (pick < 91) begin
      do_read(blk, cmd, len, 8'h00, -1, $urandom_range(0, nb - 1), -1);
    end else if (pick < 96) begin
      do_read(blk, cmd, len, 8'h00, $urandom_range(1, nb - 1), -1, -1);
    end else begin
      repeat ($urandom_range(1, 3))
        send_word(1'b0, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_directed();
    do_read(1'b0, 8'hFF, 8'd0, 8'h00, -1, -1, 8'h00);
    do_read(1'b0, 8'h00, 8'd0, 8'h01, -1, -1, 8'hFF);
    send_word(1'b0, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_word(1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    write_reg(spc_pkg::REG_MAX_BLOCK_LEN, 7'd1);
    do_read(1'b1, 8'hA5, 8'd1, 8'h00, -1, -1, 8'hFF);
    do_read(1'b1, 8'h5A, 8'd0, 8'h00, -1, -1, -1);
    do_read(1'b1, 8'h3C, 8'd255, 8'h00, -1, -1, -1);
    do_read(1'b1, 8'hC3, 8'd1, 8'h80, -1, -1, 8'h00);
    do_read(1'b0, 8'h12, 8'd0, 8'h00, 1, -1, -1);
    do_read(1'b1, 8'h34, 8'd1, 8'h00, -1, -1, -1);
    do_read(1'b0, 8'h56, 8'd0, 8'h00, -1, 1, -1);
    do_read(1'b1, 8'h78, 8'd1, 8'h00, -1, 0, -1);
  endtask

  task automatic test_register_extremes();
    logic [6:0] addrs [4];
    logic [5:0] lens [4];
    addrs = '{7'd0, 7'd127, 7'($urandom), 7'($urandom)};
    lens = '{6'd0, 6'd63, 6'd32, 6'd1};
    for (int s = 0; s < 4; s++) begin
      write_reg(spc_pkg::REG_DEVICE_ADDRESS, addrs[s]);
      write_reg(spc_pkg::REG_MAX_BLOCK_LEN, {1'b0, lens[s]});
      in_idle_en = (s % 2 == 0);
      out_idle_en = (s % 2 != 0);
      repeat (3) rand_read();
    end
  endtask

  task automatic test_random_traffic();
    int mark;
    mark = words_in - 45;
    while (words_in < TOTAL_WORDS) begin
      if (words_in - mark >= 45) begin
        write_reg(spc_pkg::REG_DEVICE_ADDRESS, 7'($urandom));
        write_reg(spc_pkg::REG_MAX_BLOCK_LEN,
                  ($urandom_range(0, 4) == 0) ? 7'd32 : 7'($urandom_range(1, 6)));
        in_idle_en = ($urandom_range(0, 3) != 0);
        out_idle_en = ($urandom_range(0, 3) != 0);
        mark = words_in;
      end
      rand_read();
    end
  endtask

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      out_hold = out_idle_en ? $urandom_range(0, 4) : 0;
      results_seen++;
      if (status != spc_pkg::STATUS_OK) error_results++;
      if (pending_results.size() == 0) begin
        report("result word with no prediction pending");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, predicted %0d", status, want.status));
        if (data_byte !== want.data)
          report($sformatf("data_byte %02h, predicted %02h", data_byte, want.data));
        if (byte_index !== want.idx)
          report($sformatf("byte_index %0d, predicted %0d", byte_index, want.idx));
        if (payload_length !== want.len)
          report($sformatf("payload_length %0d, predicted %0d", payload_length, want.len));
        if (last !== want.last)
          report($sformatf("last %0b, predicted %0b", last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_CYCLES) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_random_traffic();
    settle();
    $display("summary: %0d reads, %0d input words, %0d results checked", reads_done, words_in,
             results_seen);
    $display("summary: %0d error results, %0d mismatches", error_results, mismatches);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spc_pkg.sv
rtl/spc_fifo.sv
rtl/spc_front.sv
rtl/spc_back.sv
rtl/smbus_pec_read_checker_core.sv
sim/tb_top.sv
